>>> hdl/assert_macros.svh
// Assertion macros used by the indexed list buffer sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ILB_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ILB_NEVER(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
		else $error("forbidden condition seen");
`else
`define ILB_ASSERT(lbl, clk, rst_n, prop)
`define ILB_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

>>> hdl/ilb_pkg.sv
// Types and constants of the indexed list buffer.
package ilb_pkg;

	localparam int DEPTH_DEF  = 16;
	localparam int DATA_W_DEF = 32;

	localparam int OPCODE_W = 3;
	localparam int INDEX_W  = 5;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	typedef enum logic [OPCODE_W-1:0] {
		OP_APPEND = 3'd0,
		OP_DROP   = 3'd1,
		OP_INSERT = 3'd2,
		OP_REMOVE = 3'd3,
		OP_READ   = 3'd4
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_INDEX = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MOVE,
		S_RDWAIT,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		logic [VALUE_W-1:0] read_value;
		logic [COUNT_W-1:0] count;
		status_t            status;
	} res_t;

endpackage

>>> hdl/ilb_mem.sv
// Entry store: one write port, one read port, registered read data.
module ilb_mem #(
	parameter int DEPTH  = ilb_pkg::DEPTH_DEF,
	parameter int DATA_W = ilb_pkg::DATA_W_DEF,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/ilb_seq.sv
// Sequencer: decodes an item, checks it, and shifts entries through the store.
`include "assert_macros.svh"

module ilb_seq #(
	parameter int DEPTH  = ilb_pkg::DEPTH_DEF,
	parameter int DATA_W = ilb_pkg::DATA_W_DEF,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ilb_pkg::OPCODE_W-1:0]  opcode,
	input  logic [ilb_pkg::INDEX_W-1:0]   index,
	input  logic [ilb_pkg::VALUE_W-1:0]   value,
	output logic                          res_valid,
	output ilb_pkg::res_t                 res,
	input  logic                          res_take,
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_waddr,
	output logic [DATA_W-1:0]             mem_wdata,
	output logic                          mem_re,
	output logic [AW-1:0]                 mem_raddr,
	input  logic [DATA_W-1:0]             mem_rdata
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > ilb_pkg::INDEX_W) ? CW : ilb_pkg::INDEX_W;

	ilb_pkg::seq_state_t state_q, state_d;
	ilb_pkg::status_t    st_c;
	ilb_pkg::status_t    status_q;
	ilb_pkg::opcode_t    op_c;

	logic              accept;
	logic              ok_c;
	logic              is_full;
	logic [CMPW-1:0]   idx_w;
	logic [CMPW-1:0]   cnt_w;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     left_q;
	logic [AW-1:0]     src_q;
	logic [AW-1:0]     dst_s1;
	logic [AW-1:0]     slot_q;
	logic              pend_s1;
	logic              up_q;
	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] rd_q;

	assign op_c    = ilb_pkg::opcode_t'(opcode);
	assign idx_w   = CMPW'(index);
	assign cnt_w   = CMPW'(count_q);
	assign is_full = (count_q == CW'(DEPTH));
	assign accept  = in_valid && (state_q == ilb_pkg::S_IDLE);
	assign in_stall = (state_q != ilb_pkg::S_IDLE);
	assign ok_c    = (st_c == ilb_pkg::ST_OK);

	always_comb begin
		case (op_c)
			ilb_pkg::OP_APPEND: begin
				st_c = is_full ? ilb_pkg::ST_FULL : ilb_pkg::ST_OK;
			end
			ilb_pkg::OP_DROP: begin
				st_c = (count_q == '0) ? ilb_pkg::ST_EMPTY : ilb_pkg::ST_OK;
			end
			ilb_pkg::OP_INSERT: begin
				if (idx_w > cnt_w) begin
					st_c = ilb_pkg::ST_INDEX;
				end else if (is_full) begin
					st_c = ilb_pkg::ST_FULL;
				end else begin
					st_c = ilb_pkg::ST_OK;
				end
			end
			ilb_pkg::OP_REMOVE, ilb_pkg::OP_READ: begin
				st_c = (idx_w >= cnt_w) ? ilb_pkg::ST_INDEX : ilb_pkg::ST_OK;
			end
			default: begin
				st_c = ilb_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ilb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = dst_s1;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = src_q;
		case (state_q)
			ilb_pkg::S_IDLE: begin
				if (in_valid) begin
					if (ok_c && (op_c == ilb_pkg::OP_APPEND)) begin
						mem_we    = 1'b1;
						mem_waddr = AW'(count_q);
						mem_wdata = DATA_W'(value);
					end
					if (ok_c && (op_c == ilb_pkg::OP_READ)) begin
						mem_re    = 1'b1;
						mem_raddr = AW'(index);
					end
					if (ok_c && ((op_c == ilb_pkg::OP_INSERT) ||
					             (op_c == ilb_pkg::OP_REMOVE))) begin
						state_d = ilb_pkg::S_MOVE;
					end else if (ok_c && (op_c == ilb_pkg::OP_READ)) begin
						state_d = ilb_pkg::S_RDWAIT;
					end else begin
						state_d = ilb_pkg::S_DONE;
					end
				end
			end
			ilb_pkg::S_MOVE: begin
				mem_re = (left_q != '0);
				mem_we = pend_s1;
				if ((left_q == '0) && !pend_s1) begin
					if (up_q) begin
						mem_we    = 1'b1;
						mem_waddr = slot_q;
						mem_wdata = val_q;
					end
					state_d = ilb_pkg::S_DONE;
				end
			end
			ilb_pkg::S_RDWAIT: begin
				state_d = ilb_pkg::S_DONE;
			end
			ilb_pkg::S_DONE: begin
				if (res_take) begin
					state_d = ilb_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ilb_pkg::S_IDLE;
			end
		endcase
	end

	// count and shift control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			left_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= (state_q == ilb_pkg::S_MOVE) && (left_q != '0);
			if (accept) begin
				if (op_c == ilb_pkg::OP_INSERT) begin
					left_q <= CW'(cnt_w - idx_w);
				end else begin
					left_q <= CW'(cnt_w - idx_w - CMPW'(1));
				end
				if (ok_c) begin
					case (op_c)
						ilb_pkg::OP_APPEND, ilb_pkg::OP_INSERT: begin
							count_q <= count_q + CW'(1);
						end
						ilb_pkg::OP_DROP, ilb_pkg::OP_REMOVE: begin
							count_q <= count_q - CW'(1);
						end
						default: begin
							count_q <= count_q;
						end
					endcase
				end
			end else if ((state_q == ilb_pkg::S_MOVE) && (left_q != '0)) begin
				left_q <= left_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= st_c;
			rd_q     <= '0;
			val_q    <= DATA_W'(value);
			slot_q   <= AW'(index);
			up_q     <= (op_c == ilb_pkg::OP_INSERT);
			if (op_c == ilb_pkg::OP_INSERT) begin
				src_q <= AW'(count_q) - AW'(1);
			end else begin
				src_q <= AW'(index) + AW'(1);
			end
		end else if ((state_q == ilb_pkg::S_MOVE) && (left_q != '0)) begin
			src_q  <= up_q ? (src_q - AW'(1)) : (src_q + AW'(1));
			dst_s1 <= up_q ? (src_q + AW'(1)) : (src_q - AW'(1));
		end else if (state_q == ilb_pkg::S_RDWAIT) begin
			rd_q <= mem_rdata;
		end
	end

	assign res_valid      = (state_q == ilb_pkg::S_DONE);
	assign res.read_value = ilb_pkg::VALUE_W'(rd_q);
	assign res.count      = ilb_pkg::COUNT_W'(count_q);
	assign res.status     = status_q;

	`ILB_NEVER(a_rw_same_entry, clk, arst_n, mem_we && mem_re && (mem_waddr == mem_raddr))
	`ILB_ASSERT(a_count_only_on_accept, clk, arst_n, !accept |=> $stable(count_q))
	`ILB_ASSERT(a_done_holds, clk, arst_n, (res_valid && !res_take) |=> res_valid)
	`ILB_ASSERT(a_count_bound, clk, arst_n, accept |=> (count_q <= CW'(DEPTH)))

endmodule

>>> hdl/indexed_list_buffer_unit.sv
// Top level of the indexed list buffer: sequencer, entry store and result register.
//
// An ordered list of up to DEPTH words with append, drop last, insert at index,
// remove at index and read at index; every item gives one result with the word
// read, the count afterwards and a status. One item is worked on at a time.
// An insert or remove moves at most DEPTH - 1 entries; the single store moves
// one entry per cycle: a read of the next source overlaps the write of the
// previous one. The result register lets the next item in while a result waits.
// Entries hold nothing until written.
module indexed_list_buffer_unit #(
	parameter int DEPTH  = ilb_pkg::DEPTH_DEF,
	parameter int DATA_W = ilb_pkg::DATA_W_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ilb_pkg::OPCODE_W-1:0]  opcode,
	input  logic [ilb_pkg::INDEX_W-1:0]   index,
	input  logic [ilb_pkg::VALUE_W-1:0]   value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ilb_pkg::VALUE_W-1:0]   read_value,
	output logic [ilb_pkg::COUNT_W-1:0]   count,
	output logic [ilb_pkg::STATUS_W-1:0]  status
);

	localparam int AW = $clog2(DEPTH);

	logic              res_valid;
	logic              res_take;
	ilb_pkg::res_t     res;
	ilb_pkg::res_t     out_q;
	logic              out_valid_q;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;

	ilb_seq #(
		.DEPTH  (DEPTH),
		.DATA_W (DATA_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.index     (index),
		.value     (value),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	ilb_mem #(
		.DEPTH  (DEPTH),
		.DATA_W (DATA_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = out_q.read_value;
	assign count      = out_q.count;
	assign status     = out_q.status;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the indexed list buffer: a directed table, then random list traffic.
module tb_top;

	localparam logic [ilb_pkg::OPCODE_W-1:0] OP_SPARE5 = 3'd5;
	localparam logic [ilb_pkg::OPCODE_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [ilb_pkg::OPCODE_W-1:0] OP_SPARE7 = 3'd7;
	localparam int RANDOM_CMDS  = 400;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_REPORTS  = 60;
	localparam int DIR_COUNT    = 27;
	localparam int SLOT_W       = $clog2(ilb_pkg::DEPTH_DEF);

	typedef struct packed {
		logic [ilb_pkg::OPCODE_W-1:0] op;
		logic [ilb_pkg::INDEX_W-1:0]  idx;
		logic [ilb_pkg::VALUE_W-1:0]  val;
		logic [4:0]                   reps;
		logic                         chk;
		logic [ilb_pkg::VALUE_W-1:0]  rd;
		logic [ilb_pkg::COUNT_W-1:0]  cnt;
		ilb_pkg::status_t             st;
	} dir_row_t;

	typedef struct packed {
		logic [ilb_pkg::OPCODE_W-1:0] op;
		logic [ilb_pkg::INDEX_W-1:0]  idx;
		logic [ilb_pkg::VALUE_W-1:0]  val;
		logic                         chk;
		ilb_pkg::res_t                want;
	} list_cmd_t;

	// op, index, value, repeats, typed check, read_value, count, status
	localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
		'{ilb_pkg::OP_READ,   5'd0,  32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 5'd0,
			ilb_pkg::ST_INDEX},
		'{ilb_pkg::OP_DROP,   5'd0,  32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 5'd0,
			ilb_pkg::ST_EMPTY},
		'{ilb_pkg::OP_REMOVE, 5'd0,  32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 5'd0,
			ilb_pkg::ST_INDEX},
		'{ilb_pkg::OP_INSERT, 5'd1,  32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 5'd0,
			ilb_pkg::ST_INDEX},
		'{OP_SPARE5,          5'd0,  32'hFFFF_FFFF, 5'd1,  1'b1, 32'h0000_0000, 5'd0,
			ilb_pkg::ST_OK},
		'{ilb_pkg::OP_INSERT, 5'd0,  32'hFFFF_FFFF, 5'd1,  1'b1, 32'h0000_0000, 5'd1,
			ilb_pkg::ST_OK},
		'{ilb_pkg::OP_APPEND, 5'd31, 32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 5'd2,
			ilb_pkg::ST_OK},
		'{ilb_pkg::OP_READ,   5'd0,  32'h0000_0000, 5'd1,  1'b1, 32'hFFFF_FFFF, 5'd2,
			ilb_pkg::ST_OK},
		'{ilb_pkg::OP_READ,   5'd1,  32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 5'd2,
			ilb_pkg::ST_OK},
		'{ilb_pkg::OP_INSERT, 5'd1,  32'hA5A5_5A5A, 5'd1,  1'b0, 32'h0000_0000, 5'd0,
			ilb_pkg::ST_OK},
		'{ilb_pkg::OP_APPEND, 5'd0,  32'h1000_0000, 5'd13, 1'b0, 32'h0000_0000, 5'd0,
			ilb_pkg::ST_OK},
		'{ilb_pkg::OP_APPEND, 5'd0,  32'h1234_5678, 5'd1,  1'b1, 32'h0000_0000, 5'd16,
			ilb_pkg::ST_FULL},
		'{ilb_pkg::OP_INSERT, 5'd16, 32'h1234_5678, 5'd1,  1'b1, 32'h0000_0000, 5'd16,
			ilb_pkg::ST_FULL},
		'{ilb_pkg::OP_INSERT, 5'd17, 32'h1234_5678, 5'd1,  1'b1, 32'h0000_0000, 5'd16,
			ilb_pkg::ST_INDEX},
		'{ilb_pkg::OP_INSERT, 5'd0,  32'h1234_5678, 5'd1,  1'b1, 32'h0000_0000, 5'd16,
			ilb_pkg::ST_FULL},
		'{ilb_pkg::OP_READ,   5'd15, 32'h0000_0000, 5'd1,  1'b0, 32'h0000_0000, 5'd0,
			ilb_pkg::ST_OK},
		'{ilb_pkg::OP_READ,   5'd16, 32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 5'd16,
			ilb_pkg::ST_INDEX},
		'{ilb_pkg::OP_READ,   5'd31, 32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 5'd16,
			ilb_pkg::ST_INDEX},
		'{ilb_pkg::OP_REMOVE, 5'd0,  32'h0000_0000, 5'd1,  1'b0, 32'h0000_0000, 5'd0,
			ilb_pkg::ST_OK},
		'{ilb_pkg::OP_REMOVE, 5'd31, 32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 5'd15,
			ilb_pkg::ST_INDEX},
		'{ilb_pkg::OP_INSERT, 5'd15, 32'h5A5A_A5A5, 5'd1,  1'b0, 32'h0000_0000, 5'd0,
			ilb_pkg::ST_OK},
		'{ilb_pkg::OP_REMOVE, 5'd15, 32'h0000_0000, 5'd1,  1'b0, 32'h0000_0000, 5'd0,
			ilb_pkg::ST_OK},
		'{OP_SPARE6,          5'd9,  32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 5'd15,
			ilb_pkg::ST_OK},
		'{OP_SPARE7,          5'd22, 32'h0000_0001, 5'd1,  1'b1, 32'h0000_0000, 5'd15,
			ilb_pkg::ST_OK},
		'{ilb_pkg::OP_READ,   5'd7,  32'h0000_0000, 5'd1,  1'b0, 32'h0000_0000, 5'd0,
			ilb_pkg::ST_OK},
		'{ilb_pkg::OP_DROP,   5'd0,  32'h0000_0000, 5'd15, 1'b0, 32'h0000_0000, 5'd0,
			ilb_pkg::ST_OK},
		'{ilb_pkg::OP_DROP,   5'd0,  32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 5'd0,
			ilb_pkg::ST_EMPTY}
	};

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic [ilb_pkg::OPCODE_W-1:0] opcode;
	logic [ilb_pkg::INDEX_W-1:0]  index;
	logic [ilb_pkg::VALUE_W-1:0]  value;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [ilb_pkg::VALUE_W-1:0]  read_value;
	logic [ilb_pkg::COUNT_W-1:0]  count;
	logic [ilb_pkg::STATUS_W-1:0] status;

	logic                         cmd_chk;
	ilb_pkg::res_t                cmd_want;
	int                           idle_phase;
	logic                         in_fire;
	logic                         out_fire;

	list_cmd_t                    list_cmds[$];
	ilb_pkg::res_t                pending_replies[$];
	ilb_pkg::res_t                model_reply;
	ilb_pkg::res_t                next_reply;
	logic [ilb_pkg::VALUE_W-1:0]  shadow_words [ilb_pkg::DEPTH_DEF];
	int                           shadow_len = 0;
	int                           err_count = 0;
	int                           quiet_cycles = 0;

	indexed_list_buffer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.index     (index),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.read_value(read_value),
		.count     (count),
		.status    (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	assign in_fire  = (in_valid === 1'b1) && (in_stall === 1'b0);
	assign out_fire = (out_valid === 1'b1) && (out_stall === 1'b0);

	function automatic void predict_list_reply(input logic [ilb_pkg::OPCODE_W-1:0] op,
			input logic [ilb_pkg::INDEX_W-1:0] idx, input logic [ilb_pkg::VALUE_W-1:0] val,
			output ilb_pkg::res_t reply);
		int i;
		reply.read_value = '0;
		reply.status     = ilb_pkg::ST_OK;
		case (op)
			ilb_pkg::OP_APPEND: begin
				if (shadow_len >= ilb_pkg::DEPTH_DEF) begin
					reply.status = ilb_pkg::ST_FULL;
				end else begin
					shadow_words[shadow_len] = val;
					shadow_len++;
				end
			end
			ilb_pkg::OP_DROP: begin
				if (shadow_len == 0) reply.status = ilb_pkg::ST_EMPTY;
				else shadow_len--;
			end
			ilb_pkg::OP_INSERT: begin
				if (int'(idx) > shadow_len) begin
					reply.status = ilb_pkg::ST_INDEX;
				end else if (shadow_len >= ilb_pkg::DEPTH_DEF) begin
					reply.status = ilb_pkg::ST_FULL;
				end else begin
					for (i = shadow_len; i > int'(idx); i--)
						shadow_words[i] = shadow_words[i-1];
					shadow_words[idx[SLOT_W-1:0]] = val;
					shadow_len++;
				end
			end
			ilb_pkg::OP_REMOVE: begin
				if (int'(idx) >= shadow_len) begin
					reply.status = ilb_pkg::ST_INDEX;
				end else begin
					for (i = int'(idx); i + 1 < shadow_len; i++)
						shadow_words[i] = shadow_words[i+1];
					shadow_len--;
				end
			end
			ilb_pkg::OP_READ: begin
				if (int'(idx) >= shadow_len) reply.status = ilb_pkg::ST_INDEX;
				else reply.read_value = shadow_words[idx[SLOT_W-1:0]];
			end
			default: ;
		endcase
		reply.count = shadow_len[ilb_pkg::COUNT_W-1:0];
	endfunction

	task automatic report_mismatch(input string what,
			input logic [ilb_pkg::VALUE_W-1:0] got,
			input logic [ilb_pkg::VALUE_W-1:0] want);
		if (err_count < MAX_REPORTS)
			$display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
		err_count++;
	endtask

	// receiver back-pressure follows the phase set by the sender
	always @(posedge clk) begin
		case (idle_phase)
			0: out_stall <= ($urandom_range(99) < 65);
			1: out_stall <= ($urandom_range(99) < 33);
			default: out_stall <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		if (out_fire) begin
			if (pending_replies.size() == 0) begin
				report_mismatch("unexpected result, read_value", read_value, '0);
			end else begin
				next_reply = pending_replies.pop_front();
				if (read_value !== next_reply.read_value)
					report_mismatch("read_value", read_value, next_reply.read_value);
				if (count !== next_reply.count)
					report_mismatch("count", ilb_pkg::VALUE_W'(count),
						ilb_pkg::VALUE_W'(next_reply.count));
				if (status !== next_reply.status)
					report_mismatch("status", ilb_pkg::VALUE_W'(status),
						ilb_pkg::VALUE_W'(next_reply.status));
			end
		end
		if (in_fire) begin
			predict_list_reply(opcode, index, value, model_reply);
			pending_replies.insert(pending_replies.size(), cmd_chk ? cmd_want : model_reply);
		end
		if (!arst_n || in_fire || out_fire) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		list_cmd_t c;
		int        i;
		int        r;
		int        n;
		int        k;
		int        plan_len;
		int        grow;
		int        pick;
		int        gap_pct;

		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		opcode     <= '0;
		index      <= '0;
		value      <= '0;
		cmd_chk    <= 1'b0;
		cmd_want   <= '0;
		idle_phase <= 0;

		for (i = 0; i < DIR_COUNT; i++) begin
			for (r = 0; r < int'(DIR_ROWS[i].reps); r++) begin
				c.op              = DIR_ROWS[i].op;
				c.idx             = DIR_ROWS[i].idx;
				c.val             = DIR_ROWS[i].val + ilb_pkg::VALUE_W'(r);
				c.chk             = DIR_ROWS[i].chk;
				c.want.read_value = DIR_ROWS[i].rd;
				c.want.count      = DIR_ROWS[i].cnt;
				c.want.status     = DIR_ROWS[i].st;
				list_cmds.insert(list_cmds.size(), c);
			end
		end

		// directed table leaves the list empty
		plan_len = 0;
		grow = 1;
		for (i = 0; i < RANDOM_CMDS; i++) begin
			c.chk  = 1'b0;
			c.want = '0;
			pick = $urandom_range(7);
			c.val = (pick == 0) ? '0 : (pick == 1) ? '1 : ilb_pkg::VALUE_W'($urandom);
			if (plan_len >= ilb_pkg::DEPTH_DEF - 1 && $urandom_range(3) == 0) grow = 0;
			else if (plan_len <= 1 && $urandom_range(3) == 0) grow = 1;
			else if ($urandom_range(39) == 0) grow = !grow;
			if ($urandom_range(99) < 15) begin
				c.op  = ilb_pkg::OPCODE_W'($urandom_range(7));
				c.idx = ilb_pkg::INDEX_W'($urandom_range(31));
			end else begin
				pick = $urandom_range(99);
				if (grow)
					c.op = (pick < 50) ? ilb_pkg::OP_APPEND :
						(pick < 80) ? ilb_pkg::OP_INSERT :
						(pick < 90) ? ilb_pkg::OP_READ : ilb_pkg::OP_REMOVE;
				else
					c.op = (pick < 35) ? ilb_pkg::OP_DROP :
						(pick < 70) ? ilb_pkg::OP_REMOVE :
						(pick < 85) ? ilb_pkg::OP_READ : ilb_pkg::OP_INSERT;
				if (plan_len == 0 && (c.op == ilb_pkg::OP_READ || c.op == ilb_pkg::OP_REMOVE))
					c.op = ilb_pkg::OP_APPEND;
				if (c.op == ilb_pkg::OP_INSERT)
					c.idx = ilb_pkg::INDEX_W'($urandom_range(plan_len));
				else if (plan_len > 0)
					c.idx = ilb_pkg::INDEX_W'($urandom_range(plan_len - 1));
				else
					c.idx = ilb_pkg::INDEX_W'($urandom_range(31));
			end
			case (c.op)
				ilb_pkg::OP_APPEND: if (plan_len < ilb_pkg::DEPTH_DEF) plan_len++;
				ilb_pkg::OP_DROP:   if (plan_len > 0) plan_len--;
				ilb_pkg::OP_INSERT:
					if (int'(c.idx) <= plan_len && plan_len < ilb_pkg::DEPTH_DEF) plan_len++;
				ilb_pkg::OP_REMOVE: if (int'(c.idx) < plan_len) plan_len--;
				default: ;
			endcase
			list_cmds.insert(list_cmds.size(), c);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		n = list_cmds.size();
		k = 0;
		while (k < n) begin
			if (k < n / 3) begin
				idle_phase <= 0;
				gap_pct = 33;
			end else if (k < 2 * n / 3) begin
				idle_phase <= 1;
				gap_pct = 65;
			end else begin
				idle_phase <= 2;
				gap_pct = 0;
			end
			if ($urandom_range(99) < gap_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end else begin
				in_valid <= 1'b1;
				opcode   <= list_cmds[k].op;
				index    <= list_cmds[k].idx;
				value    <= list_cmds[k].val;
				cmd_chk  <= list_cmds[k].chk;
				cmd_want <= list_cmds[k].want;
				@(posedge clk);
				while (in_stall !== 1'b0) @(posedge clk);
				k++;
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule
